/* rtl/core/phase_angle_dimmer_with_serial_level_top_assert.svh */
// Assertion macros used by the checker file of the dimmer block.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message.
`ifndef PHASE_ANGLE_DIMMER_WITH_SERIAL_LEVEL_TOP_ASSERT_SVH
`define PHASE_ANGLE_DIMMER_WITH_SERIAL_LEVEL_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PADSL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PADSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/padsl_pkg.sv */
// ----------------------------------------------------------------------------
// padsl_pkg
// Shared types and constants of the phase-angle dimmer with serial level.
// ----------------------------------------------------------------------------
`default_nettype none

package padsl_pkg;

    // Debounce register
    localparam int CFG_BITS       = 8;
    localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = 8'd8;

    // Input transaction: five pin samples, padded to one byte
    localparam int IN_BITS        = 5;
    localparam int IN_TDATA_BITS  = 8;

    // Pin sample, cs_level in bit 0 up to timer_tick in bit 4
    typedef struct packed {
        logic timer_tick;
        logic zc_level;
        logic data_level;
        logic sclk_level;
        logic cs_level;
    } t_pins;

endpackage

`default_nettype wire

/* rtl/core/phase_angle_dimmer_with_serial_level_top.sv */
// ----------------------------------------------------------------------------
// phase_angle_dimmer_with_serial_level_top
// Triac phase-angle dimmer: serial level receive, zero-cross debounce,
// phase timer and gate firing compare, one pin sample per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_axis_*) carries one sample of the pins per transaction:
//   chip select, serial clock, serial data, zero-cross level and timer tick.
//   Master channel (m_axis_*) returns exactly one result per sample: triac
//   drive, latched dim level, captured half period and a level-updated flag.
//   i_cfg_we / i_cfg_wdata write the debounce sample count (reset 8); write
//   it only while no sample is in flight.
//   The sample waits in the input register; edge detection, receive,
//   debounce, timer update and the period * level multiply with the firing
//   compare then run combinationally into the output register.
//   Throughput is one sample per cycle while m_axis_tready does not stall
//   the output register; the state update loop sets that figure.
//   Reset (i_rst_n low, synchronous) empties both registers, sets the level
//   to half scale and clears timer, period and drive.
//   When m_axis_tready is low the result holds in the output register and the
//   input register still takes one more sample; s_axis_tready then drops.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_angle_dimmer_with_serial_level_top #(
    parameter int TIMER_BITS = 16,
    parameter int LEVEL_BITS = 8
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    // fields from bit 0: cs_level, sclk_level, data_level, zc_level, timer_tick
    input  wire  [padsl_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
    input  wire                                     s_axis_tvalid,
    output logic                                    s_axis_tready,
    // fields from bit 0: triac_drive, dim_level, half_period, level_updated
    output logic [((TIMER_BITS+LEVEL_BITS+9)/8)*8-1:0] m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire                                     m_axis_tready,
    input  wire                                     i_cfg_we,
    input  wire  [padsl_pkg::CFG_BITS-1:0]          i_cfg_wdata
);

    localparam int OUT_BITS       = TIMER_BITS + LEVEL_BITS + 2;
    localparam int OUT_TDATA_BITS = ((TIMER_BITS + LEVEL_BITS + 9) / 8) * 8;
    localparam int PROD_BITS      = TIMER_BITS + LEVEL_BITS;

    // Configuration
    logic [padsl_pkg::CFG_BITS-1:0] r_debounce_samples;

    // Input register
    logic              r_in_valid;
    padsl_pkg::t_pins  r_pins;

    // Block state
    logic                           r_prev_cs, n_prev_cs;
    logic                           r_prev_sclk, n_prev_sclk;
    logic                           r_prev_zc, n_prev_zc;
    logic [LEVEL_BITS-1:0]          r_shift_value, n_shift_value;
    logic [LEVEL_BITS-1:0]          r_bit_mask, n_bit_mask;
    logic [LEVEL_BITS-1:0]          r_level, n_level;
    logic [TIMER_BITS-1:0]          r_period, n_period;
    logic [TIMER_BITS-1:0]          r_phase_timer, n_phase_timer;
    logic                           r_drive, n_drive;
    logic [padsl_pkg::CFG_BITS-1:0] r_debounce_count, n_debounce_count;
    logic                           r_debounce_active, n_debounce_active;

    // Output register
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_data, n_out_data;

    logic                  w_advance;
    logic                  w_cs_rise, w_cs_fall, w_sclk_rise, w_zc_fall;
    logic                  w_capture;
    logic                  w_updated;
    logic [PROD_BITS-1:0]  w_prod;
    logic [TIMER_BITS-1:0] w_mark;

    assign w_advance     = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_BITS'(r_out_data);

    always_comb begin
        w_cs_rise   = r_pins.cs_level & ~r_prev_cs;
        w_cs_fall   = ~r_pins.cs_level & r_prev_cs;
        w_sclk_rise = r_pins.sclk_level & ~r_prev_sclk;
        w_zc_fall   = ~r_pins.zc_level & r_prev_zc;

        n_shift_value     = r_shift_value;
        n_bit_mask        = r_bit_mask;
        n_level           = r_level;
        n_period          = r_period;
        n_phase_timer     = r_phase_timer;
        n_drive           = r_drive;
        n_debounce_count  = r_debounce_count;
        n_debounce_active = r_debounce_active;
        w_capture         = 1'b0;
        w_updated         = 1'b0;

        // serial receive, LSB first
        if (w_cs_rise) begin
            n_shift_value = '0;
            n_bit_mask    = LEVEL_BITS'(1);
        end else if (w_sclk_rise && r_pins.cs_level && (r_bit_mask != '0)) begin
            if (r_pins.data_level) begin
                n_shift_value = r_shift_value | r_bit_mask;
            end
            n_bit_mask = r_bit_mask << 1;
        end
        if (w_cs_fall) begin
            n_level   = n_shift_value;
            w_updated = 1'b1;
        end

        // zero-cross debounce
        if (w_zc_fall) begin
            n_debounce_active = 1'b1;
            n_debounce_count  = '0;
            if (r_debounce_samples == '0) begin
                w_capture = 1'b1;
            end
        end else if (r_debounce_active) begin
            if (r_pins.zc_level) begin
                n_debounce_active = 1'b0;
                n_debounce_count  = '0;
            end else begin
                n_debounce_count = r_debounce_count + padsl_pkg::CFG_BITS'(1);
                if (n_debounce_count >= r_debounce_samples) begin
                    w_capture = 1'b1;
                end
            end
        end

        // capture takes the timer before any tick of this sample
        if (w_capture) begin
            n_period          = r_phase_timer;
            n_phase_timer     = '0;
            n_drive           = 1'b0;
            n_debounce_active = 1'b0;
            n_debounce_count  = '0;
        end else if (r_pins.timer_tick) begin
            n_phase_timer = r_phase_timer + TIMER_BITS'(1);
        end

        // fire once the timer reaches period - period * level / 2^LEVEL_BITS
        w_prod = PROD_BITS'(n_period) * PROD_BITS'(n_level);
        w_mark = n_period - w_prod[PROD_BITS-1:LEVEL_BITS];
        if (n_phase_timer >= w_mark) begin
            n_drive = 1'b1;
        end

        n_prev_cs   = r_pins.cs_level;
        n_prev_sclk = r_pins.sclk_level;
        n_prev_zc   = r_pins.zc_level;

        n_out_data = {w_updated, n_period, n_level, n_drive};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_samples <= padsl_pkg::DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            r_debounce_samples <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_pins <= padsl_pkg::t_pins'(s_axis_tdata[padsl_pkg::IN_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cs         <= 1'b0;
            r_prev_sclk       <= 1'b0;
            r_prev_zc         <= 1'b1;
            r_shift_value     <= '0;
            r_bit_mask        <= '0;
            r_level           <= LEVEL_BITS'(1) << (LEVEL_BITS - 1);
            r_period          <= '0;
            r_phase_timer     <= '0;
            r_drive           <= 1'b0;
            r_debounce_count  <= '0;
            r_debounce_active <= 1'b0;
        end else if (w_advance) begin
            r_prev_cs         <= n_prev_cs;
            r_prev_sclk       <= n_prev_sclk;
            r_prev_zc         <= n_prev_zc;
            r_shift_value     <= n_shift_value;
            r_bit_mask        <= n_bit_mask;
            r_level           <= n_level;
            r_period          <= n_period;
            r_phase_timer     <= n_phase_timer;
            r_drive           <= n_drive;
            r_debounce_count  <= n_debounce_count;
            r_debounce_active <= n_debounce_active;
        end
    end

    // hold the result until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/padsl_checker.sv */
// ----------------------------------------------------------------------------
// padsl_checker
// Port-level checks of the dimmer top level, bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "phase_angle_dimmer_with_serial_level_top_assert.svh"

module padsl_checker #(
    parameter int TIMER_BITS = 16,
    parameter int LEVEL_BITS = 8
) (
    input wire                                        i_clk,
    input wire                                        i_rst_n,
    input wire [padsl_pkg::IN_TDATA_BITS-1:0]         s_axis_tdata,
    input wire                                        s_axis_tvalid,
    input wire                                        s_axis_tready,
    input wire [((TIMER_BITS+LEVEL_BITS+9)/8)*8-1:0]  m_axis_tdata,
    input wire                                        m_axis_tvalid,
    input wire                                        m_axis_tready,
    input wire                                        i_cfg_we,
    input wire [padsl_pkg::CFG_BITS-1:0]              i_cfg_wdata
);

    localparam int PERIOD_LSB = LEVEL_BITS + 1;
    localparam int PERIOD_MSB = LEVEL_BITS + TIMER_BITS;

    logic w_period_zero;
    logic w_idle_inputs;

    assign w_period_zero = (m_axis_tdata[PERIOD_MSB:PERIOD_LSB] == '0);
    // samples and config writes are visible here; neither may leave X behind
    assign w_idle_inputs = ~s_axis_tvalid | (s_axis_tdata == s_axis_tdata) |
                           ~i_cfg_we | (i_cfg_wdata == i_cfg_wdata);

    // a stalled result keeps its value
    `PADSL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // reset empties the output register
    `PADSL_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !m_axis_tvalid, "result valid right after reset")

    // with no result waiting the block always takes a sample
    `PADSL_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid && w_idle_inputs, s_axis_tready, "input stalled with empty output")

    // a zero period puts the firing mark at zero, so the gate is on
    `PADSL_ASSERT_SAME(a_zero_period_fires, i_clk, i_rst_n, m_axis_tvalid && w_period_zero, m_axis_tdata[0], "zero period without drive")

endmodule

bind phase_angle_dimmer_with_serial_level_top padsl_checker #(
    .TIMER_BITS (TIMER_BITS),
    .LEVEL_BITS (LEVEL_BITS)
) u_padsl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_wdata   (i_cfg_wdata)
);

`default_nettype wire

/* bench/phase_angle_dimmer_with_serial_level_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Phase-angle dimmer with serial level: stream-level testbench
// Feeds pin samples (chip select, serial clock and data, zero-cross, tick)
// through the slave channel in bursts and checks every result on the master
// channel against a cycle-free behavioral predictor. Directed rows cover the
// serial receive corner cases and debounce cancel/immediate capture; a tick
// run covers long periods at zero and at full level; random phases under
// several debounce settings send level frames of varied length and noise.
// ----------------------------------------------------------------------------
module phase_angle_dimmer_with_serial_level_top_test;

    localparam int TIMER_W = 16;
    localparam int LEVEL_W = 8;
    localparam int OUT_W   = ((TIMER_W + LEVEL_W + 9) / 8) * 8;

    // Result fields, lowest bit first: drive, level, period, update flag
    typedef struct packed {
        logic [OUT_W-27:0]  spare;
        logic               level_updated;
        logic [TIMER_W-1:0] half_period;
        logic [LEVEL_W-1:0] dim_level;
        logic               triac_drive;
    } t_dimmer_out;

    typedef struct packed {
        padsl_pkg::t_pins pins;
        logic             typed_check;
        t_dimmer_out      want;
    } t_sample;

    typedef enum logic {ROW_SAMPLE, ROW_CONFIG} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        padsl_pkg::t_pins   pins;
        logic [7:0]         cfg_value;
        logic               typed_check;
        logic               exp_drive;
        logic [LEVEL_W-1:0] exp_level;
        logic [TIMER_W-1:0] exp_period;
        logic               exp_upd;
    } t_row;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic [padsl_pkg::IN_TDATA_BITS-1:0] s_axis_tdata = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [OUT_W-1:0]                    m_axis_tdata;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [padsl_pkg::CFG_BITS-1:0]      i_cfg_wdata = '0;

    phase_angle_dimmer_with_serial_level_top #(
        .TIMER_BITS(TIMER_W),
        .LEVEL_BITS(LEVEL_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Pins are written {timer_tick, zc_level, data_level, sclk_level, cs_level}
    t_row directed_rows [14] = '{
        '{ROW_SAMPLE, 5'b01000, 8'd0,   1'b1, 1'b1, 8'd128, 16'd0, 1'b0},
        '{ROW_SAMPLE, 5'b11111, 8'd0,   1'b0, 1'b0, 8'd0,   16'd0, 1'b0},
        '{ROW_SAMPLE, 5'b01101, 8'd0,   1'b0, 1'b0, 8'd0,   16'd0, 1'b0},
        '{ROW_SAMPLE, 5'b01111, 8'd0,   1'b0, 1'b0, 8'd0,   16'd0, 1'b0},
        '{ROW_SAMPLE, 5'b01000, 8'd0,   1'b1, 1'b1, 8'd1,   16'd0, 1'b1},
        '{ROW_SAMPLE, 5'b01110, 8'd0,   1'b0, 1'b0, 8'd0,   16'd0, 1'b0},
        '{ROW_SAMPLE, 5'b01001, 8'd0,   1'b0, 1'b0, 8'd0,   16'd0, 1'b0},
        '{ROW_SAMPLE, 5'b01000, 8'd0,   1'b1, 1'b1, 8'd0,   16'd0, 1'b1},
        '{ROW_SAMPLE, 5'b10000, 8'd0,   1'b0, 1'b0, 8'd0,   16'd0, 1'b0},
        '{ROW_SAMPLE, 5'b11000, 8'd0,   1'b0, 1'b0, 8'd0,   16'd0, 1'b0},
        '{ROW_CONFIG, 5'b00000, 8'd0,   1'b0, 1'b0, 8'd0,   16'd0, 1'b0},
        '{ROW_SAMPLE, 5'b11000, 8'd0,   1'b0, 1'b0, 8'd0,   16'd0, 1'b0},
        '{ROW_SAMPLE, 5'b10000, 8'd0,   1'b0, 1'b0, 8'd0,   16'd0, 1'b0},
        '{ROW_SAMPLE, 5'b00000, 8'd0,   1'b0, 1'b0, 8'd0,   16'd0, 1'b0}
    };

    // Predictor state
    logic [7:0]         debounce_setting;
    logic               last_cs, last_sclk, last_zc;
    logic [LEVEL_W-1:0] rx_word, rx_mask, dim_setting;
    logic [TIMER_W-1:0] captured_period, phase_count;
    logic               gate_on, zc_pending;
    logic [7:0]         zc_count;

    t_sample     sample_q [$];
    t_dimmer_out result_q [$];
    t_sample     cur_sample;

    int burst_left = 1;
    int gap_left = 0;
    int queued_total = 0;
    int accepted_total = 0;
    int capture_count = 0;
    int latch_count = 0;
    int config_writes = 0;
    int mismatch_count = 0;

    // Stimulus-side shaping of the zero-cross waveform
    logic [7:0] dbn_plan = 8'd8;
    logic       zc_now = 1'b1;
    int         zc_left = 20;
    logic       zc_quiet = 1'b0;

    int stall_window = 0;
    int stall_mode = 0;
    int rx_cycle = 0;

    function automatic t_dimmer_out advance_dimmer(padsl_pkg::t_pins p);
        logic               cs_rise, cs_fall, sclk_rise, zc_fall, fire_now;
        logic [31:0]        scaled;
        logic [TIMER_W-1:0] mark;
        t_dimmer_out        r;
        cs_rise   = p.cs_level && !last_cs;
        cs_fall   = !p.cs_level && last_cs;
        sclk_rise = p.sclk_level && !last_sclk;
        zc_fall   = !p.zc_level && last_zc;
        fire_now  = 1'b0;
        r         = '0;

        if (cs_rise) begin
            rx_word = '0;
            rx_mask = LEVEL_W'(1);
        end else if (sclk_rise && p.cs_level && rx_mask != '0) begin
            if (p.data_level) begin
                rx_word = rx_word | rx_mask;
            end
            rx_mask = rx_mask << 1;
        end
        if (cs_fall) begin
            dim_setting     = rx_word;
            r.level_updated = 1'b1;
            latch_count++;
        end

        if (zc_fall) begin
            zc_pending = 1'b1;
            zc_count   = '0;
            if (debounce_setting == '0) begin
                fire_now = 1'b1;
            end
        end else if (zc_pending) begin
            if (p.zc_level) begin
                zc_pending = 1'b0;
                zc_count   = '0;
            end else begin
                zc_count = zc_count + 8'd1;
                if (zc_count >= debounce_setting) begin
                    fire_now = 1'b1;
                end
            end
        end

        // A tick in the capture sample is lost
        if (fire_now) begin
            captured_period = phase_count;
            phase_count     = '0;
            gate_on         = 1'b0;
            zc_pending      = 1'b0;
            zc_count        = '0;
            capture_count++;
        end else if (p.timer_tick) begin
            phase_count = phase_count + TIMER_W'(1);
        end

        scaled = 32'(captured_period) * 32'(dim_setting);
        mark   = captured_period - TIMER_W'(scaled >> LEVEL_W);
        if (phase_count >= mark) begin
            gate_on = 1'b1;
        end

        last_cs   = p.cs_level;
        last_sclk = p.sclk_level;
        last_zc   = p.zc_level;

        r.triac_drive = gate_on;
        r.dim_level   = dim_setting;
        r.half_period = captured_period;
        return r;
    endfunction

    // Sender: predict on each accepted transaction, then present the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid    <= 1'b0;
            debounce_setting = padsl_pkg::DEBOUNCE_RESET;
            last_cs          = 1'b0;
            last_sclk        = 1'b0;
            last_zc          = 1'b1;
            rx_word          = '0;
            rx_mask          = '0;
            dim_setting      = {1'b1, {(LEVEL_W-1){1'b0}}};
            captured_period  = '0;
            phase_count      = '0;
            gate_on          = 1'b0;
            zc_pending       = 1'b0;
            zc_count         = '0;
        end else begin
            if (i_cfg_we) begin
                debounce_setting = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                t_dimmer_out r;
                r = advance_dimmer(cur_sample.pins);
                if (cur_sample.typed_check) begin
                    r = cur_sample.want;
                end
                result_q.push_back(r);
                accepted_total++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    cur_sample    = sample_q.pop_front();
                    s_axis_tdata  <= padsl_pkg::IN_TDATA_BITS'(cur_sample.pins);
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall mode is redrawn at the end of each random-length window
    always @(posedge i_clk) begin
        rx_cycle++;
        if (stall_window == 0) begin
            stall_window = $urandom_range(50, 300);
            stall_mode   = $urandom_range(0, 3);
        end else begin
            stall_window--;
        end
        case (stall_mode)
            0, 1:    m_axis_tready <= 1'b1;
            2:       m_axis_tready <= ($urandom_range(0, 99) >= 40);
            default: m_axis_tready <= ((rx_cycle % 5) >= 2);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_dimmer_out got, want;
            got = m_axis_tdata;
            if (result_q.size() == 0) begin
                $error("unexpected result transaction 0x%h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = result_q.pop_front();
                if (got.triac_drive !== want.triac_drive) begin
                    $error("triac_drive: expected %0d, got %0d",
                           want.triac_drive, got.triac_drive);
                    mismatch_count++;
                end
                if (got.dim_level !== want.dim_level) begin
                    $error("dim_level: expected %0d, got %0d",
                           want.dim_level, got.dim_level);
                    mismatch_count++;
                end
                if (got.half_period !== want.half_period) begin
                    $error("half_period: expected %0d, got %0d",
                           want.half_period, got.half_period);
                    mismatch_count++;
                end
                if (got.level_updated !== want.level_updated) begin
                    $error("level_updated: expected %0d, got %0d",
                           want.level_updated, got.level_updated);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic push_raw(padsl_pkg::t_pins p);
        t_sample s;
        s.pins        = p;
        s.typed_check = 1'b0;
        s.want        = '0;
        sample_q.push_back(s);
        queued_total++;
    endtask

    // Zero-cross and tick come from the waveform shaper unless held quiet
    task automatic push_pin(logic cs, logic sclk, logic data);
        padsl_pkg::t_pins p;
        p.cs_level   = cs;
        p.sclk_level = sclk;
        p.data_level = data;
        if (zc_quiet) begin
            p.zc_level   = 1'b1;
            p.timer_tick = 1'b0;
        end else begin
            p.zc_level   = zc_now;
            p.timer_tick = ($urandom_range(0, 3) != 0);
            if (zc_left > 0) begin
                zc_left--;
            end else if (zc_now) begin
                zc_now = 1'b0;
                // mostly long enough to capture, sometimes cut short
                if ($urandom_range(0, 3) == 0) begin
                    zc_left = $urandom_range(0, int'(dbn_plan));
                end else begin
                    zc_left = int'(dbn_plan) + $urandom_range(0, 3);
                end
            end else begin
                zc_now  = 1'b1;
                zc_left = $urandom_range(10, 120);
            end
        end
        push_raw(p);
    endtask

    task automatic push_frame(logic [LEVEL_W-1:0] value, int nbits);
        logic d;
        push_pin(1'b1, 1'b0, $urandom_range(0, 1));
        for (int i = 0; i < nbits; i++) begin
            d = (i < LEVEL_W) ? value[i] : 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 2)) push_pin(1'b1, 1'b0, d);
            push_pin(1'b1, 1'b1, d);
        end
        push_pin(1'b0, 1'b0, $urandom_range(0, 1));
    endtask

    task automatic wait_for_idle();
        do begin
            @(negedge i_clk);
        end while (sample_q.size() != 0 || s_axis_tvalid || result_q.size() != 0);
    endtask

    task automatic write_debounce(logic [7:0] value);
        wait_for_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        dbn_plan = value;
        config_writes++;
    endtask

    task automatic run_random_phase(logic [7:0] dbn, int budget);
        int                 target;
        logic [LEVEL_W-1:0] value;
        write_debounce(dbn);
        target = queued_total + budget;
        while (queued_total < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    case ($urandom_range(0, 5))
                        0:       value = '0;
                        1:       value = '1;
                        default: value = LEVEL_W'($urandom);
                    endcase
                    push_frame(value,
                               ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : LEVEL_W);
                end
                6, 7: begin
                    // chip select low, clock may still toggle
                    repeat ($urandom_range(1, 12))
                        push_pin(1'b0, $urandom_range(0, 1), $urandom_range(0, 1));
                end
                default: begin
                    repeat ($urandom_range(1, 8))
                        push_pin($urandom_range(0, 1), $urandom_range(0, 1),
                                 $urandom_range(0, 1));
                end
            endcase
        end
    endtask

    initial begin
        t_sample s;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                write_debounce(directed_rows[i].cfg_value);
            end else begin
                s.pins                = directed_rows[i].pins;
                s.typed_check         = directed_rows[i].typed_check;
                s.want                = '0;
                s.want.triac_drive    = directed_rows[i].exp_drive;
                s.want.dim_level      = directed_rows[i].exp_level;
                s.want.half_period    = directed_rows[i].exp_period;
                s.want.level_updated  = directed_rows[i].exp_upd;
                sample_q.push_back(s);
                queued_total++;
            end
        end

        // Long period at zero level, then full level and a second capture
        write_debounce(8'd0);
        push_raw(5'b01000);
        push_raw(5'b00000);
        repeat (200) push_raw(5'b11000);
        push_raw(5'b10000);
        push_raw(5'b01000);
        zc_quiet = 1'b1;
        push_frame('1, LEVEL_W);
        zc_quiet = 1'b0;
        repeat (200) push_raw(5'b11000);
        push_raw(5'b00000);
        push_raw(5'b01000);

        run_random_phase(8'd1, 180);
        run_random_phase(8'd255, 180);
        run_random_phase(8'd0, 180);
        run_random_phase(8'($urandom_range(2, 40)), 180);
        run_random_phase(8'd8, 180);

        wait_for_idle();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d pin samples under %0d debounce settings,",
                 accepted_total, config_writes);
        $display("with %0d zero-cross captures and %0d level latches.",
                 capture_count, latch_count);
        if (mismatch_count == 0 && result_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
